/* sv/sadc_pkg.sv */
// Shared constants, types and helpers for the SPI ADC readout controller.
package sadc_pkg;

  localparam int CMD_BITS  = 5;
  localparam int READ_BITS = 12;

  localparam int PHASE_W  = 6;
  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 11;
  localparam int CURR_W   = 12;
  localparam int IDX_W    = 3;

  localparam logic [PHASE_W-1:0] CMD_END  = PHASE_W'(2 * CMD_BITS);
  localparam logic [PHASE_W-1:0] READ_END = PHASE_W'(2 * CMD_BITS + 2 * READ_BITS);

  localparam logic [CHAN_W-1:0] MAX_CHANNEL = 4'd7;
  localparam logic [CURR_W-1:0] FULL_SCALE  = 12'd2048;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase_count;
    logic                 busy;
    logic [READ_BITS-1:0] shift_in;
    logic                 channel_bit;
    logic                 mosi_level;
  } state_t;

  typedef struct packed {
    logic                cs_pin;
    logic                clk_pin;
    logic                mosi_pin;
    logic                done_res;
    logic [SAMPLE_W-1:0] sample;
    logic [CURR_W-1:0]   current;
    logic                bad_channel;
  } result_t;

  // Command byte sent MSB first: 1,1,channel bit,0,0 followed by padding zeros.
  function automatic logic cmd_bit(input logic ch_bit, input logic [IDX_W-1:0] idx);
    logic [7:0] cmd;
    cmd = {2'b11, ch_bit, 5'b00000};
    return cmd[3'd7 - idx];
  endfunction

endpackage

/* sv/sadc_step.sv */
// Per-request sequencer step: next state and pin/result levels.
module sadc_step (
  input  sadc_pkg::state_t             state,
  input  logic                         req_type,
  input  logic [sadc_pkg::CHAN_W-1:0]  channel,
  input  logic                         miso_level,
  output sadc_pkg::state_t             state_next,
  output sadc_pkg::result_t            result
);

  logic [sadc_pkg::PHASE_W-1:0]   q;
  logic [sadc_pkg::PHASE_W-1:0]   p_inc;
  logic [sadc_pkg::READ_BITS-1:0] shifted;
  logic [sadc_pkg::SAMPLE_W-1:0]  smp;

  assign q       = state.phase_count - sadc_pkg::CMD_END;
  assign p_inc   = state.phase_count + sadc_pkg::PHASE_W'(1);
  assign shifted = {state.shift_in[sadc_pkg::READ_BITS-2:0], ~miso_level};
  assign smp     = sadc_pkg::SAMPLE_W'(shifted >> 1);

  always_comb begin
    state_next         = state;
    result.cs_pin      = state.busy;
    result.clk_pin     = 1'b1;
    result.mosi_pin    = state.mosi_level;
    result.done_res    = 1'b0;
    result.sample      = '0;
    result.current     = '0;
    result.bad_channel = 1'b0;

    if (req_type == sadc_pkg::REQ_START) begin
      if (!state.busy) begin
        if (channel > sadc_pkg::MAX_CHANNEL) begin
          result.bad_channel = 1'b1;
          result.cs_pin      = 1'b0;
        end else begin
          state_next.busy        = 1'b1;
          state_next.phase_count = '0;
          state_next.shift_in    = '0;
          state_next.channel_bit = channel[0];
          result.cs_pin          = 1'b1;
        end
      end
    end else if (state.busy) begin
      if (state.phase_count < sadc_pkg::CMD_END) begin
        if (!state.phase_count[0]) begin
          state_next.mosi_level = ~sadc_pkg::cmd_bit(state.channel_bit,
              sadc_pkg::IDX_W'(state.phase_count >> 1));
          result.mosi_pin = state_next.mosi_level;
          result.clk_pin  = 1'b0;
        end
        state_next.phase_count = p_inc;
      end else if (state.phase_count < sadc_pkg::READ_END) begin
        if (!q[0]) begin
          // first read low phase has nothing to sample yet
          if (q >= sadc_pkg::PHASE_W'(2)) state_next.shift_in = shifted;
          result.clk_pin = 1'b0;
        end
        state_next.phase_count = p_inc;
      end else begin
        state_next.shift_in    = shifted;
        state_next.busy        = 1'b0;
        state_next.phase_count = '0;
        result.sample          = smp;
        result.current         = sadc_pkg::FULL_SCALE - {1'b0, smp};
        result.done_res        = 1'b1;
        result.cs_pin          = 1'b0;
      end
    end
  end

endmodule

/* sv/spi_adc_readout_controller.sv */
// Top level of the SPI ADC readout controller: state and result registers.
// Usage:
//   Input channel (in_valid/in_stall): each request is a start (req_type 0,
//   channel 0..7) or one half-period tick of the SPI clock (req_type 1) that
//   carries the data-in level seen during the previous result's pin levels.
//   Output channel (out_valid/out_stall): one result per request, holding the
//   pin levels (cs, clk, mosi) to drive until the next tick, plus done_res
//   with sample/current at the end of a conversion, or bad_channel.
//   A result is registered in the cycle after its request is taken.
//   Throughput: one request per cycle; the result register lets a new request
//   in whenever the held result is being taken or the register is empty.
//   A full conversion needs one start and 2*(5+12)+1 = 35 ticks.
//   While out_stall holds a result, in_stall is raised and the held result
//   stays unchanged.
//   Reset clears the sequencer to idle (cs 0, mosi level 1) and empties the
//   result register.
module spi_adc_readout_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            req_type,
  input  logic [sadc_pkg::CHAN_W-1:0]     channel,
  input  logic                            miso_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            cs_pin,
  output logic                            clk_pin,
  output logic                            mosi_pin,
  output logic                            done_res,
  output logic [sadc_pkg::SAMPLE_W-1:0]   sample,
  output logic [sadc_pkg::CURR_W-1:0]     current,
  output logic                            bad_channel
);

  sadc_pkg::state_t  state;
  sadc_pkg::state_t  state_next;
  sadc_pkg::result_t result;
  sadc_pkg::result_t res_next;
  logic              in_acc;

  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  sadc_step u_step (
    .state      (state),
    .req_type   (req_type),
    .channel    (channel),
    .miso_level (miso_level),
    .state_next (state_next),
    .result     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase_count <= '0;
      state.busy        <= 1'b0;
      state.shift_in    <= '0;
      state.channel_bit <= 1'b0;
      state.mosi_level  <= 1'b1;
      out_valid         <= 1'b0;
    end else begin
      if (in_acc) state <= state_next;
      out_valid <= in_acc | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) result <= res_next;
  end

  assign cs_pin      = result.cs_pin;
  assign clk_pin     = result.clk_pin;
  assign mosi_pin    = result.mosi_pin;
  assign done_res    = result.done_res;
  assign sample      = result.sample;
  assign current     = result.current;
  assign bad_channel = result.bad_channel;

  a_done_cs_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!cs_pin && !bad_channel))
    else $error("done result with chip select high or error flag");

  a_current: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (current == sadc_pkg::FULL_SCALE - {1'b0, sample}))
    else $error("current does not match sample");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    state.busy |-> (state.phase_count <= sadc_pkg::READ_END))
    else $error("phase counter ran past the end of the transfer");

  a_bad_no_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && req_type == sadc_pkg::REQ_START && !state.busy
     && channel > sadc_pkg::MAX_CHANNEL) |=> (!state.busy && bad_channel))
    else $error("bad channel started a transfer");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    (in_acc && state.busy && req_type == sadc_pkg::REQ_TICK
     && state.phase_count == sadc_pkg::READ_END) |=> (!state.busy && done_res))
    else $error("last tick did not finish the conversion");

endmodule

/* verif/tb.sv */
// Testbench for the SPI ADC readout controller: directed table, then random conversions.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQ_COUNT   = 1300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int PAUSE_SEQ   = 12;

  // Pin patterns for the rows that are easy to read by hand.
  localparam sadc_pkg::result_t IDLE_PINS = '{1'b0, 1'b1, 1'b1, 1'b0, 11'd0, 12'd0, 1'b0};
  localparam sadc_pkg::result_t BAD_PINS  = '{1'b0, 1'b1, 1'b1, 1'b0, 11'd0, 12'd0, 1'b1};
  localparam sadc_pkg::result_t HELD_PINS = '{1'b1, 1'b1, 1'b1, 1'b0, 11'd0, 12'd0, 1'b0};
  localparam sadc_pkg::result_t CMD_LOW   = '{1'b1, 1'b0, 1'b0, 1'b0, 11'd0, 12'd0, 1'b0};
  localparam sadc_pkg::result_t CMD_HIGH  = '{1'b1, 1'b1, 1'b0, 1'b0, 11'd0, 12'd0, 1'b0};
  localparam sadc_pkg::result_t NO_PINS   = '0;

  typedef enum int {
    MISO_LOW,
    MISO_HIGH,
    MISO_RAND,
    MISO_TOGGLE
  } miso_mode_t;

  typedef struct {
    logic                        rq;
    logic [sadc_pkg::CHAN_W-1:0] ch;
    logic                        mi;
    bit                          typed;
    sadc_pkg::result_t           want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic                          req_type;
  logic [sadc_pkg::CHAN_W-1:0]   channel;
  logic                          miso_level;
  logic                          out_valid;
  logic                          out_stall;
  logic                          cs_pin;
  logic                          clk_pin;
  logic                          mosi_pin;
  logic                          done_res;
  logic [sadc_pkg::SAMPLE_W-1:0] sample;
  logic [sadc_pkg::CURR_W-1:0]   current;
  logic                          bad_channel;

  // Sequencer copy used for prediction.
  logic [sadc_pkg::PHASE_W-1:0]   sq_phase = '0;
  logic                           sq_busy  = 1'b0;
  logic [sadc_pkg::READ_BITS-1:0] sq_shift = '0;
  logic                           sq_chbit = 1'b0;
  logic                           sq_mosi  = 1'b1;

  sadc_pkg::result_t pending_readings[$];
  int         mismatches     = 0;
  int         readings_seen  = 0;
  int         cycle_count    = 0;
  bit         sender_quiet   = 1'b0;
  miso_mode_t miso_mode      = MISO_RAND;

  dir_row_t dir_rows [23] = '{
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b1, 1'b1, IDLE_PINS},
    '{sadc_pkg::REQ_TICK,  4'd15, 1'b0, 1'b1, IDLE_PINS},
    '{sadc_pkg::REQ_START, 4'd15, 1'b0, 1'b1, BAD_PINS},
    '{sadc_pkg::REQ_START, 4'd8,  1'b1, 1'b1, BAD_PINS},
    '{sadc_pkg::REQ_START, 4'd7,  1'b0, 1'b1, HELD_PINS},
    '{sadc_pkg::REQ_START, 4'd0,  1'b0, 1'b1, HELD_PINS},
    '{sadc_pkg::REQ_START, 4'd15, 1'b1, 1'b1, HELD_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b1, 1'b1, CMD_LOW},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b0, 1'b1, CMD_HIGH},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b1, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b1, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b1, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b1, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_START, 4'd9,  1'b0, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b1, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b1, 1'b0, NO_PINS},
    '{sadc_pkg::REQ_TICK,  4'd0,  1'b1, 1'b0, NO_PINS}
  };

  spi_adc_readout_controller uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .channel    (channel),
    .miso_level (miso_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cs_pin     (cs_pin),
    .clk_pin    (clk_pin),
    .mosi_pin   (mosi_pin),
    .done_res   (done_res),
    .sample     (sample),
    .current    (current),
    .bad_channel(bad_channel)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advances the sequencer copy by one request and returns the pin levels it reports.
  function automatic sadc_pkg::result_t spi_readout_step(
      input logic rq, input logic [sadc_pkg::CHAN_W-1:0] ch, input logic mi);
    sadc_pkg::result_t res;
    logic [4:0]        cmd_word;
    int                p;
    int                q;
    res = '0;
    res.cs_pin = sq_busy;
    res.clk_pin = 1'b1;
    p = int'(sq_phase);
    if (rq == sadc_pkg::REQ_START) begin
      if (!sq_busy) begin
        if (ch > sadc_pkg::MAX_CHANNEL) begin
          res.bad_channel = 1'b1;
          res.cs_pin = 1'b0;
        end else begin
          sq_busy = 1'b1;
          sq_phase = '0;
          sq_shift = '0;
          sq_chbit = ch[0];
          res.cs_pin = 1'b1;
        end
      end
    end else if (sq_busy) begin
      if (p < 2 * sadc_pkg::CMD_BITS) begin
        if (p % 2 == 0) begin
          // command goes out MSB first: 1, 1, channel bit, 0, 0
          cmd_word = {2'b11, sq_chbit, 2'b00};
          sq_mosi = ~cmd_word[sadc_pkg::CMD_BITS - 1 - p / 2];
          res.clk_pin = 1'b0;
        end
        res.cs_pin = 1'b1;
        sq_phase = sadc_pkg::PHASE_W'(p + 1);
      end else if (p < 2 * sadc_pkg::CMD_BITS + 2 * sadc_pkg::READ_BITS) begin
        q = p - 2 * sadc_pkg::CMD_BITS;
        if (q % 2 == 0) begin
          if (q >= 2) sq_shift = {sq_shift[sadc_pkg::READ_BITS-2:0], ~mi};
          res.clk_pin = 1'b0;
        end
        res.cs_pin = 1'b1;
        sq_phase = sadc_pkg::PHASE_W'(p + 1);
      end else begin
        sq_shift = {sq_shift[sadc_pkg::READ_BITS-2:0], ~mi};
        res.sample = sq_shift[sadc_pkg::READ_BITS-1:1];
        res.current = sadc_pkg::FULL_SCALE - {1'b0, res.sample};
        res.done_res = 1'b1;
        res.cs_pin = 1'b0;
        sq_busy = 1'b0;
        sq_phase = '0;
      end
    end else begin
      res.cs_pin = 1'b0;
    end
    res.mosi_pin = sq_mosi;
    return res;
  endfunction

  function automatic int idle_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic pick_miso();
    case (miso_mode)
      MISO_LOW:    return 1'b0;
      MISO_HIGH:   return 1'b1;
      MISO_TOGGLE: return sq_phase[1];
      default:     return 1'($urandom);
    endcase
  endfunction

  task automatic send_req(input logic rq, input logic [sadc_pkg::CHAN_W-1:0] ch,
                          input logic mi, input bit typed, input sadc_pkg::result_t want);
    sadc_pkg::result_t predicted;
    int                gap;
    in_valid   <= 1'b1;
    req_type   <= rq;
    channel    <= ch;
    miso_level <= mi;
    do @(posedge clk); while (in_stall);
    predicted = spi_readout_step(rq, ch, mi);
    pending_readings.push_back(typed ? want : predicted);
    gap = idle_len(sender_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic match_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    sadc_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request outstanding, expected none, %s cs=%0d done=%0d",
                 $time, "actual", cs_pin, done_res);
      end else begin
        want = pending_readings.pop_front();
        match_field("cs_pin", want.cs_pin, cs_pin);
        match_field("clk_pin", want.clk_pin, clk_pin);
        match_field("mosi_pin", want.mosi_pin, mosi_pin);
        match_field("done_res", want.done_res, done_res);
        match_field("sample", want.sample, sample);
        match_field("current", want.current, current);
        match_field("bad_channel", want.bad_channel, bad_channel);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side back-pressure.
  initial begin
    bit hold_done;
    int s;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!hold_done && readings_seen >= HOLD_AFTER) begin
        // long hold-off so the block fills up and stalls requests
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
        repeat (2) @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b0;
        repeat (40) @(posedge clk);
      end else begin
        s = idle_len(1'b0);
        if (s > 0) begin
          out_stall <= 1'b1;
          repeat (s) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    int                          sent;
    int                          seq;
    logic [sadc_pkg::CHAN_W-1:0] ch;
    sent = 0;
    seq = 0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= sadc_pkg::REQ_TICK;
    channel    <= '0;
    miso_level <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].rq, dir_rows[i].ch, dir_rows[i].mi, dir_rows[i].typed,
               dir_rows[i].want);
      sent++;
    end

    // finish the conversion left open by the table
    while (sq_busy) begin
      send_req(sadc_pkg::REQ_TICK, 4'($urandom), 1'($urandom), 1'b0, NO_PINS);
      sent++;
    end

    while (sent < REQ_COUNT) begin
      seq++;
      sender_quiet = ($urandom_range(0, 3) == 0);
      miso_mode = miso_mode_t'($urandom_range(0, 3));
      if (seq == PAUSE_SEQ) begin
        in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
      end
      // occasional idle tick between conversions
      if ($urandom_range(0, 5) == 0)
        send_req(sadc_pkg::REQ_TICK, 4'($urandom), 1'($urandom), 1'b0, NO_PINS);
      if ($urandom_range(0, 7) == 0) ch = 4'($urandom_range(8, 15));
      else ch = 4'($urandom_range(0, 7));
      send_req(sadc_pkg::REQ_START, ch, 1'($urandom), 1'b0, NO_PINS);
      sent++;
      while (sq_busy) begin
        if ($urandom_range(0, 15) == 0) begin
          // start request while a transfer runs
          send_req(sadc_pkg::REQ_START, 4'($urandom), 1'($urandom), 1'b0, NO_PINS);
        end else begin
          send_req(sadc_pkg::REQ_TICK, 4'($urandom), pick_miso(), 1'b0, NO_PINS);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/sadc_pkg.sv
sv/sadc_step.sv
sv/spi_adc_readout_controller.sv
verif/tb.sv
